/* design/lsf_pkg.sv */
// ---------------------------------------------------------------------------
// lsf_pkg: shared definitions for the line substring filter
// Constants, codes, result and control structures and small helper
// functions used by the cell row, the result queue and the top level.
// ---------------------------------------------------------------------------
package lsf_pkg;

  // Longest pattern that the cell row can follow, one cell for each byte.
  localparam int MAX_PATTERN   = 32;
  // Pattern bytes held in the configuration registers.
  localparam int PATTERN_BYTES = 32;
  // A line without a newline is closed after this many bytes.
  localparam int LINE_CHUNK    = 1023;

  localparam int PATTERN_LENGTH_W = 6;
  localparam int WORD_W           = 64;
  localparam int WORD_BYTES       = WORD_W / 8;
  localparam int PATTERN_WORDS    = PATTERN_BYTES / WORD_BYTES;
  localparam int CFG_INDEX_W      = 3;
  localparam int COUNT_W          = 32;

  localparam int LEN_W     = $clog2(MAX_PATTERN + 1);
  localparam int LEN_CMP_W = (PATTERN_LENGTH_W > LEN_W) ? PATTERN_LENGTH_W : LEN_W;
  localparam int CHUNK_W   = (LINE_CHUNK > 1) ? $clog2(LINE_CHUNK) : 1;

  // Result queue depth: two beats may be pushed while two are still waiting.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] NEWLINE = 8'h0A;

  typedef enum logic {
    OP_DATA = 1'b0,
    OP_EOF  = 1'b1
  } op_t;

  typedef enum logic {
    KIND_VERDICT = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_LENGTH = 3'd0,
    REG_PATTERN_LO     = 3'd1,
    REG_PATTERN_MID_LO = 3'd2,
    REG_PATTERN_MID_HI = 3'd3,
    REG_PATTERN_HI     = 3'd4,
    REG_CASE_FOLD      = 3'd5,
    REG_INVERT_SEL     = 3'd6,
    REG_QUIET_MODE     = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic               kind;
    logic               selected;
    logic [COUNT_W-1:0] line_number;
    logic [COUNT_W-1:0] selected_total;
    logic               exit_status;
    logic               last;
  } result_t;

  // Beats handed to the result queue in one cycle (none, one or two).
  typedef struct packed {
    logic [1:0] beats;
    result_t    first;
    result_t    second;
  } push_t;

  typedef struct packed {
    logic                   full;
    logic [QUEUE_CNT_W-1:0] level;
  } queue_status_t;

  // Common controls broadcast along the cell row.
  typedef struct packed {
    logic update;
    logic clear;
    logic fold_case;
  } cell_ctl_t;

  function automatic logic [7:0] fold(input logic [7:0] c, input logic fold_en);
    logic [7:0] r;
    r = c;
    if (fold_en && c >= 8'd65 && c <= 8'd90) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

endpackage

/* design/lsf_cell.sv */
// ---------------------------------------------------------------------------
// lsf_cell: one position of the shift-and match vector
// Holds one match bit, compares its pattern byte with the current text byte
// and takes the match bit of its left-hand neighbour on every data beat.
// ---------------------------------------------------------------------------
module lsf_cell (
  input  logic                clk,
  input  logic                rst,
  input  lsf_pkg::cell_ctl_t  ctl,
  input  logic [7:0]          data_fold,
  input  logic [7:0]          pattern_byte,
  input  logic                enable,
  input  logic                match_in,
  output logic                match,
  output logic                match_next
);

  logic byte_equal;

  assign byte_equal = (lsf_pkg::fold(pattern_byte, ctl.fold_case) == data_fold);
  assign match_next = match_in & byte_equal & enable;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      match <= 1'b0;
    end else if (ctl.update) begin
      match <= match_next;
    end
  end

endmodule

/* design/lsf_result_queue.sv */
// ---------------------------------------------------------------------------
// lsf_result_queue: short result queue in front of the output channel
// A shifting queue whose head drives the output ports; up to two beats
// enter in a cycle while the head leaves when the receiver takes it.
// ---------------------------------------------------------------------------
module lsf_result_queue (
  input  logic                      clk,
  input  logic                      rst,
  input  lsf_pkg::push_t            push,
  input  logic                      out_stall,
  output logic                      out_valid,
  output lsf_pkg::result_t          head,
  output lsf_pkg::queue_status_t    status
);

  lsf_pkg::result_t                         slots [lsf_pkg::QUEUE_DEPTH];
  lsf_pkg::result_t                         slots_next [lsf_pkg::QUEUE_DEPTH];
  logic [lsf_pkg::QUEUE_CNT_W-1:0]          level;
  logic [lsf_pkg::QUEUE_CNT_W-1:0]          level_next;
  logic [lsf_pkg::QUEUE_CNT_W-1:0]          level_kept;
  logic                                     pop;

  assign out_valid = (level != '0);
  assign head      = slots[0];
  assign pop       = out_valid & ~out_stall;
  assign level_kept = level - lsf_pkg::QUEUE_CNT_W'(pop);
  assign level_next = level_kept + lsf_pkg::QUEUE_CNT_W'(push.beats);

  assign status.level = level;
  assign status.full  = (level > lsf_pkg::QUEUE_CNT_W'(lsf_pkg::QUEUE_DEPTH - 2));

  always_comb begin
    for (int j = 0; j < lsf_pkg::QUEUE_DEPTH; j++) begin
      if (pop && (j + 1 < lsf_pkg::QUEUE_DEPTH)) begin
        slots_next[j] = slots[j + 1];
      end else begin
        slots_next[j] = slots[j];
      end
      if (push.beats != 2'd0 && level_kept == lsf_pkg::QUEUE_CNT_W'(j)) begin
        slots_next[j] = push.first;
      end else if (push.beats == 2'd2 && level_kept + 1'b1 == lsf_pkg::QUEUE_CNT_W'(j)) begin
        slots_next[j] = push.second;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
    end else begin
      level <= level_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < lsf_pkg::QUEUE_DEPTH; j++) begin
      slots[j] <= slots_next[j];
    end
  end

endmodule

/* design/line_substring_filter_top.sv */
// ---------------------------------------------------------------------------
// line_substring_filter_top: byte-serial substring line filter
// Scans a text stream one byte a beat with a row of shift-and cells, closes
// lines at a newline or a full chunk, and reports verdicts and file totals.
// ---------------------------------------------------------------------------
//
// Channel   Direction  Handshake              Payload
// in        sink       in_valid / in_stall    op, data_byte
// out       source     out_valid / out_stall  kind, selected, line_number,
//                                             selected_total, exit_status, last
// cfg       sink       cfg_wr_en              cfg_index, cfg_data
//
// One input beat is taken every cycle while in_stall is low. The cell row,
// the line bookkeeping and both counters are updated in the cycle the beat
// is accepted, so the rate is one byte per clock while in_stall is low. An
// end of file that closes an open line yields two output beats unless quiet
// mode is set; the four-entry result queue absorbs them, and in_stall rises
// only while the queue holds three or more beats, which only output
// back-pressure causes. Reset is synchronous and clears the match vector,
// line state, counters, the result queue and all configuration registers.
//
module line_substring_filter_top (
  input  logic                              clk,
  input  logic                              rst,
  // Input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              op,
  input  logic [7:0]                        data_byte,
  // Output channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              kind,
  output logic                              selected,
  output logic [lsf_pkg::COUNT_W-1:0]       line_number,
  output logic [lsf_pkg::COUNT_W-1:0]       selected_total,
  output logic                              exit_status,
  output logic                              last,
  // Configuration write port
  input  logic                              cfg_wr_en,
  input  logic [lsf_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [lsf_pkg::WORD_W-1:0]        cfg_data
);

  // Configuration registers.
  logic [lsf_pkg::PATTERN_LENGTH_W-1:0]                         pattern_length;
  logic [lsf_pkg::PATTERN_WORDS-1:0][lsf_pkg::WORD_W-1:0]       pattern_words;
  logic                                                         case_fold;
  logic                                                         invert_sel;
  logic                                                         quiet_mode;

  // Line state and counters.
  logic                               line_hit;
  logic                               line_open;
  logic [lsf_pkg::CHUNK_W-1:0]        chunk_length;
  logic [lsf_pkg::COUNT_W-1:0]        line_counter;
  logic [lsf_pkg::COUNT_W-1:0]        selected_counter;

  logic                               in_accept;
  logic                               data_accept;
  logic                               eof_accept;
  logic                               chunk_end;
  logic                               line_end;
  logic                               line_close;
  logic                               new_hit;
  logic                               line_hit_now;
  logic                               line_selected;
  logic [lsf_pkg::COUNT_W-1:0]        line_counter_after;
  logic [lsf_pkg::COUNT_W-1:0]        selected_counter_after;
  logic [lsf_pkg::LEN_CMP_W-1:0]      len_clamped;
  logic [lsf_pkg::LEN_W-1:0]          len_eff;
  logic [7:0]                         data_fold;

  logic [lsf_pkg::MAX_PATTERN-1:0]    match_vector;
  logic [lsf_pkg::MAX_PATTERN-1:0]    match_next;
  logic [lsf_pkg::MAX_PATTERN-1:0]    end_hit;

  lsf_pkg::cell_ctl_t                 cell_ctl;
  lsf_pkg::result_t                   verdict;
  lsf_pkg::result_t                   summary;
  lsf_pkg::result_t                   head;
  lsf_pkg::push_t                     push;
  lsf_pkg::queue_status_t             q_status;

  // -------------------------------------------------------------------------
  // Configuration writes. They take effect from the next data beat and leave
  // the match vector as it stands.
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      pattern_words  <= '0;
      case_fold      <= 1'b0;
      invert_sel     <= 1'b0;
      quiet_mode     <= 1'b0;
    end else if (cfg_wr_en) begin
      case (lsf_pkg::cfg_reg_t'(cfg_index))
        lsf_pkg::REG_PATTERN_LENGTH: begin
          pattern_length <= cfg_data[lsf_pkg::PATTERN_LENGTH_W-1:0];
        end
        lsf_pkg::REG_PATTERN_LO:     pattern_words[0] <= cfg_data;
        lsf_pkg::REG_PATTERN_MID_LO: pattern_words[1] <= cfg_data;
        lsf_pkg::REG_PATTERN_MID_HI: pattern_words[2] <= cfg_data;
        lsf_pkg::REG_PATTERN_HI:     pattern_words[3] <= cfg_data;
        lsf_pkg::REG_CASE_FOLD:      case_fold  <= cfg_data[0];
        lsf_pkg::REG_INVERT_SEL:     invert_sel <= cfg_data[0];
        lsf_pkg::REG_QUIET_MODE:     quiet_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // A length beyond the cell row is treated as a full-length pattern.
  assign len_clamped = (lsf_pkg::LEN_CMP_W'(pattern_length) >
                        lsf_pkg::LEN_CMP_W'(lsf_pkg::MAX_PATTERN))
                       ? lsf_pkg::LEN_CMP_W'(lsf_pkg::MAX_PATTERN)
                       : lsf_pkg::LEN_CMP_W'(pattern_length);
  assign len_eff = len_clamped[lsf_pkg::LEN_W-1:0];

  // -------------------------------------------------------------------------
  // Handshake and line-end detection.
  // -------------------------------------------------------------------------
  assign in_stall    = q_status.full;
  assign in_accept   = in_valid & ~in_stall;
  assign data_accept = in_accept & (op == lsf_pkg::OP_DATA);
  assign eof_accept  = in_accept & (op == lsf_pkg::OP_EOF);

  // The chunk length never exceeds one less than the chunk size between beats.
  assign chunk_end  = (chunk_length == lsf_pkg::CHUNK_W'(lsf_pkg::LINE_CHUNK - 1));
  assign line_end   = data_accept & ((data_byte == lsf_pkg::NEWLINE) | chunk_end);
  assign line_close = line_end | (eof_accept & line_open);

  assign data_fold = lsf_pkg::fold(data_byte, case_fold);

  assign cell_ctl.update    = data_accept;
  assign cell_ctl.clear     = line_end | eof_accept;
  assign cell_ctl.fold_case = case_fold;

  // -------------------------------------------------------------------------
  // Cell row: cell i follows whether the last i+1 bytes equal the first i+1
  // pattern bytes. Cells past the pattern length are held at zero.
  // -------------------------------------------------------------------------
  for (genvar i = 0; i < lsf_pkg::MAX_PATTERN; i++) begin : g_cell
    logic [7:0] pattern_byte;
    logic       match_in;

    if (i < lsf_pkg::PATTERN_BYTES) begin : g_byte
      assign pattern_byte =
        pattern_words[i / lsf_pkg::WORD_BYTES][(i % lsf_pkg::WORD_BYTES) * 8 +: 8];
    end else begin : g_zero
      assign pattern_byte = 8'h00;
    end

    if (i == 0) begin : g_first
      assign match_in = 1'b1;
    end else begin : g_chain
      assign match_in = match_vector[i - 1];
    end

    lsf_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctl          (cell_ctl),
      .data_fold    (data_fold),
      .pattern_byte (pattern_byte),
      .enable       (lsf_pkg::LEN_W'(i) < len_eff),
      .match_in     (match_in),
      .match        (match_vector[i]),
      .match_next   (match_next[i])
    );

    // Only the cell at the end of the pattern reports a complete match.
    assign end_hit[i] = match_next[i] & (len_eff == lsf_pkg::LEN_W'(i + 1));
  end

  // An empty pattern matches every byte and hence every line.
  assign new_hit      = (len_eff == '0) | (|end_hit);
  assign line_hit_now = data_accept ? (line_hit | new_hit) : line_hit;
  assign line_selected = line_hit_now ^ invert_sel;

  assign line_counter_after     = line_close ? lsf_pkg::sat_inc(line_counter) : line_counter;
  assign selected_counter_after = (line_close && line_selected)
                                  ? lsf_pkg::sat_inc(selected_counter) : selected_counter;

  // -------------------------------------------------------------------------
  // Result beats. A verdict is last unless an end-of-file summary follows it.
  // -------------------------------------------------------------------------
  always_comb begin
    verdict.kind           = lsf_pkg::KIND_VERDICT;
    verdict.selected       = line_selected;
    verdict.line_number    = line_counter_after;
    verdict.selected_total = selected_counter_after;
    verdict.exit_status    = 1'b0;
    verdict.last           = ~eof_accept;

    summary.kind           = lsf_pkg::KIND_SUMMARY;
    summary.selected       = 1'b0;
    summary.line_number    = line_counter_after;
    summary.selected_total = selected_counter_after;
    summary.exit_status    = (selected_counter_after == '0);
    summary.last           = 1'b1;

    push.beats  = 2'd0;
    push.first  = verdict;
    push.second = summary;
    if (eof_accept) begin
      if (line_close && !quiet_mode) begin
        push.beats = 2'd2;
      end else begin
        push.beats = 2'd1;
        push.first = summary;
      end
    end else if (line_end && !quiet_mode) begin
      push.beats = 2'd1;
    end
  end

  // -------------------------------------------------------------------------
  // Line state and counters. End of file starts the next file afresh.
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst || eof_accept) begin
      line_hit         <= 1'b0;
      line_open        <= 1'b0;
      chunk_length     <= '0;
      line_counter     <= '0;
      selected_counter <= '0;
    end else if (data_accept) begin
      line_hit         <= line_end ? 1'b0 : line_hit_now;
      line_open        <= ~line_end;
      chunk_length     <= line_end ? '0 : chunk_length + 1'b1;
      line_counter     <= line_counter_after;
      selected_counter <= selected_counter_after;
    end
  end

  lsf_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .head      (head),
    .status    (q_status)
  );

  assign kind           = head.kind;
  assign selected       = head.selected;
  assign line_number    = head.line_number;
  assign selected_total = head.selected_total;
  assign exit_status    = head.exit_status;
  assign last           = head.last;

  // -------------------------------------------------------------------------
  // Assertions.
  // -------------------------------------------------------------------------
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_status.level <= lsf_pkg::QUEUE_CNT_W'(lsf_pkg::QUEUE_DEPTH))
    else $error("result queue holds more beats than it has entries");

  a_chunk_bound: assert property (@(posedge clk) disable iff (rst)
    chunk_length < lsf_pkg::CHUNK_W'(lsf_pkg::LINE_CHUNK - 1) || chunk_length ==
    lsf_pkg::CHUNK_W'(lsf_pkg::LINE_CHUNK - 1))
    else $error("chunk length ran past the chunk size");

  a_eof_clears: assert property (@(posedge clk) disable iff (rst)
    eof_accept |=> (line_counter == '0 && selected_counter == '0 && !line_open))
    else $error("end of file did not clear the line state");

  a_summary_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == lsf_pkg::KIND_SUMMARY) |-> (exit_status == (selected_total == '0)))
    else $error("summary exit status disagrees with its selected total");

endmodule
